FILE: design/sts_pkg.sv
// Shared constants, payload types and address helpers of the step trigger sequencer.
package sts_pkg;

	// Geometry of the pattern store.
	localparam int LANES         = 16;
	localparam int BLOCKS        = 16;
	localparam int STEPS         = 16;
	localparam int SUBSTEPS      = 12;
	localparam int TRIGGER_LANES = 8;

	// Fixed field widths.
	localparam int MASK_W = 8;
	localparam int PAT_W  = 12;
	localparam int LEN_W  = 5;

	// Derived widths and depths.
	localparam int LANE_W     = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int BLK_W      = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
	localparam int STEP_W     = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int SUB_W      = (SUBSTEPS > 1) ? $clog2(SUBSTEPS) : 1;
	localparam int PAT_DEPTH  = LANES * BLOCKS * STEPS;
	localparam int PAT_AW     = (PAT_DEPTH > 1) ? $clog2(PAT_DEPTH) : 1;
	localparam int LOOP_DEPTH = LANES * BLOCKS;
	localparam int LOOP_AW    = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;

	// Number of lanes that show up in the trigger mask.
	localparam int MASK_N_A = (TRIGGER_LANES < LANES) ? TRIGGER_LANES : LANES;
	localparam int MASK_N   = (MASK_N_A < MASK_W) ? MASK_N_A : MASK_W;

	// Reciprocal used to split the sub-tick count by the sub-step count.
	localparam int DIV_SHIFT = 16;
	localparam int DIV_RECIP = (1 << DIV_SHIFT) / SUBSTEPS + 1;
	localparam int DIV_PW    = 8 + DIV_SHIFT + 1;

	// Request kinds.
	localparam logic [2:0] KIND_TICK    = 3'd0;
	localparam logic [2:0] KIND_TOGGLE  = 3'd1;
	localparam logic [2:0] KIND_WR_PAT  = 3'd2;
	localparam logic [2:0] KIND_WR_LEN  = 3'd3;
	localparam logic [2:0] KIND_SEL_BLK = 3'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  sub;
		logic        locked;
		logic [3:0]  lane;
		logic [3:0]  block;
		logic [3:0]  step;
		logic [11:0] pattern_word;
		logic [4:0]  loop_length;
	} req_t;

	typedef struct packed {
		logic [7:0] trigger_mask;
		logic       trigger_changed;
		logic       playing;
		logic       clock_unlock;
	} rsp_t;

	// Linear address of a pattern word.
	function automatic logic [PAT_AW-1:0] pat_addr(input int lane, input int blk,
		input int stp);
		int a;
		a = (lane * BLOCKS + blk) * STEPS + stp;
		return PAT_AW'(a);
	endfunction

	// Linear address of a loop length.
	function automatic logic [LOOP_AW-1:0] loop_addr(input int lane, input int blk);
		int a;
		a = lane * BLOCKS + blk;
		return LOOP_AW'(a);
	endfunction

endpackage

FILE: design/sts_if.sv
// Valid/ready channel interfaces for sequencer requests and results.
interface sts_req_if;
	logic            valid;
	logic            ready;
	sts_pkg::req_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sts_rsp_if;
	logic            valid;
	logic            ready;
	sts_pkg::rsp_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/step_trigger_sequencer.sv
// Multi-lane trigger step sequencer: transport, pattern store and per-tick trigger mask.
// After reset the block sweeps its pattern memory to zero, one word a cycle, over all
// LANES*BLOCKS*STEPS words, and takes no request until that sweep ends. Each request then
// returns exactly one result. Write, select and toggle requests, and ticks that leave the
// transport outside PLAY, pass only through the decode and emit states before their result
// is registered. A tick that ends in PLAY runs a short sequencer around the read port of
// each memory: the divide and modulo states find the sub-step, then, on sub-step zero of a
// tick that was already in PLAY, a walk over all 16 lanes through the loop-length memory
// read port, then a walk over the 8 trigger lanes through the pattern memory read port,
// and the emit state loads the result register. A new request is taken only when the
// previous one has handed its result to the output register. A result still waiting there
// lets one more request in, which then holds in its last cycle until the output is free.
module step_trigger_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	sts_req_if.sink    req,
	sts_rsp_if.source  rsp
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_DIV,
		ST_MOD,
		ST_ADV,
		ST_MASK,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		XP_STOP,
		XP_RESET,
		XP_PLAY
	} xport_t;

	state_t                         state_q;
	xport_t                         xport_q;
	sts_pkg::req_t                  in_q;
	logic [7:0]                     quo_q;
	logic [sts_pkg::SUB_W-1:0]      sub_step_q;
	logic [sts_pkg::BLK_W-1:0]      sel_blk_q;
	logic [sts_pkg::BLK_W-1:0]      play_blk_q;
	logic [sts_pkg::MASK_W-1:0]     last_mask_q;
	logic [sts_pkg::STEP_W-1:0]     step_ctr_q [sts_pkg::LANES];
	logic                           adv_ok_q;
	logic [sts_pkg::PAT_AW-1:0]     clr_idx_q;
	logic [sts_pkg::LANE_W-1:0]     rd_idx_q;
	logic                           rd_run_q;
	logic                           wb_vld_s1;
	logic [sts_pkg::LANE_W-1:0]     wb_idx_s1;
	logic [sts_pkg::MASK_W-1:0]     acc_q;
	logic [sts_pkg::MASK_W-1:0]     res_mask_q;
	logic                           res_changed_q;
	logic                           res_unlock_q;
	logic                           rsp_vld_q;
	sts_pkg::rsp_t                  rsp_data_q;

	// Memories and their registered read data.
	logic [sts_pkg::PAT_W-1:0]      pat_mem [sts_pkg::PAT_DEPTH];
	logic [sts_pkg::PAT_W-1:0]      pat_rd_q;
	logic [sts_pkg::LEN_W-1:0]      loop_mem [sts_pkg::LOOP_DEPTH];
	logic [sts_pkg::LEN_W-1:0]      loop_rd_q;
	logic                           loop_vld_q [sts_pkg::LOOP_DEPTH];
	logic                           loop_rdv_q;

	logic                           pat_we;
	logic [sts_pkg::PAT_AW-1:0]     pat_wa;
	logic [sts_pkg::PAT_W-1:0]      pat_wd;
	logic [sts_pkg::PAT_AW-1:0]     pat_ra;
	logic                           loop_we;
	logic [sts_pkg::LOOP_AW-1:0]    loop_wa;
	logic [sts_pkg::LOOP_AW-1:0]    loop_ra;

	logic [sts_pkg::DIV_PW-1:0]     div_prod;
	logic [7:0]                     rem;
	logic [sts_pkg::LEN_W-1:0]      len_eff;
	logic [sts_pkg::STEP_W:0]       ctr_nxt;
	logic                           ctr_wrap;
	logic [sts_pkg::MASK_W-1:0]     mask_nxt;
	logic                           accept;
	logic                           lane_ok;
	logic                           blk_ok;
	logic                           step_ok;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_data_q;

	// Address range checks of the latched request.
	assign lane_ok = int'(in_q.lane) < sts_pkg::LANES;
	assign blk_ok  = int'(in_q.block) < sts_pkg::BLOCKS;
	assign step_ok = int'(in_q.step) < sts_pkg::STEPS;

	// Sub-step: quotient by reciprocal, then remainder.
	assign div_prod = sts_pkg::DIV_PW'(in_q.sub) * sts_pkg::DIV_PW'(sts_pkg::DIV_RECIP);
	assign rem      = in_q.sub - 8'(int'(quo_q) * sts_pkg::SUBSTEPS);

	// Step advance of the lane whose loop length just came back.
	always_comb begin
		len_eff  = loop_rdv_q ? loop_rd_q : sts_pkg::LEN_W'(sts_pkg::STEPS);
		ctr_nxt  = {1'b0, step_ctr_q[wb_idx_s1]} + 1'b1;
		ctr_wrap = (int'(ctr_nxt) >= int'(len_eff)) || (int'(ctr_nxt) >= sts_pkg::STEPS);
	end

	// Trigger mask with the bit of the lane whose pattern word just came back.
	always_comb begin
		mask_nxt = acc_q;
		for (int j = 0; j < sts_pkg::MASK_W; j++) begin
			if (wb_vld_s1 && (int'(wb_idx_s1) == j)) begin
				mask_nxt[j] = pat_rd_q[sub_step_q];
			end
		end
	end

	// Memory port selection.
	always_comb begin
		pat_we  = 1'b0;
		pat_wa  = clr_idx_q;
		pat_wd  = '0;
		loop_we = 1'b0;
		loop_wa = sts_pkg::loop_addr(int'(in_q.lane), int'(in_q.block));
		if (state_q == ST_CLEAR) begin
			pat_we = 1'b1;
		end else if (state_q == ST_DECODE && in_q.kind == sts_pkg::KIND_WR_PAT &&
			lane_ok && blk_ok && step_ok) begin
			pat_we = 1'b1;
			pat_wa = sts_pkg::pat_addr(int'(in_q.lane), int'(in_q.block), int'(in_q.step));
			pat_wd = in_q.pattern_word;
		end
		if (state_q == ST_DECODE && in_q.kind == sts_pkg::KIND_WR_LEN && lane_ok && blk_ok) begin
			loop_we = 1'b1;
		end
		pat_ra  = sts_pkg::pat_addr(int'(rd_idx_q), int'(play_blk_q),
			int'(step_ctr_q[rd_idx_q]));
		loop_ra = sts_pkg::loop_addr(int'(rd_idx_q), int'(play_blk_q));
	end

	// Pattern memory.
	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_mem[pat_wa] <= pat_wd;
		end
		pat_rd_q <= pat_mem[pat_ra];
	end

	// Loop-length memory.
	always_ff @(posedge clk) begin
		if (loop_we) begin
			loop_mem[loop_wa] <= in_q.loop_length;
		end
		loop_rd_q  <= loop_mem[loop_ra];
		loop_rdv_q <= loop_vld_q[loop_ra];
	end

	// Loop-length valid bits: an entry never written reads as STEPS.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sts_pkg::LOOP_DEPTH; i++) begin
				loop_vld_q[i] <= 1'b0;
			end
		end else if (loop_we) begin
			loop_vld_q[loop_wa] <= 1'b1;
		end
	end

	// Request, quotient and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= req.data;
		end
		if (state_q == ST_DIV) begin
			quo_q <= div_prod[sts_pkg::DIV_SHIFT +: 8];
		end
		if (state_q == ST_EMIT && (!rsp_vld_q || rsp.ready)) begin
			rsp_data_q.trigger_mask    <= res_mask_q;
			rsp_data_q.trigger_changed <= res_changed_q;
			rsp_data_q.playing         <= (xport_q == XP_PLAY);
			rsp_data_q.clock_unlock    <= res_unlock_q;
		end
	end

	// Sequencer and transport.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			xport_q       <= XP_STOP;
			sub_step_q    <= '0;
			sel_blk_q     <= '0;
			play_blk_q    <= '0;
			last_mask_q   <= '0;
			adv_ok_q      <= 1'b0;
			clr_idx_q     <= '0;
			rd_idx_q      <= '0;
			rd_run_q      <= 1'b0;
			wb_vld_s1     <= 1'b0;
			wb_idx_s1     <= '0;
			acc_q         <= '0;
			res_mask_q    <= '0;
			res_changed_q <= 1'b0;
			res_unlock_q  <= 1'b0;
			rsp_vld_q     <= 1'b0;
			for (int i = 0; i < sts_pkg::LANES; i++) begin
				step_ctr_q[i] <= '0;
			end
		end else begin
			if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (int'(clr_idx_q) == sts_pkg::PAT_DEPTH - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					res_mask_q    <= last_mask_q;
					res_changed_q <= 1'b0;
					res_unlock_q  <= 1'b0;
					state_q       <= ST_EMIT;
					case (in_q.kind)
						sts_pkg::KIND_TICK: begin
							case (xport_q)
								XP_STOP: begin
									res_unlock_q <= 1'b1;
								end
								XP_RESET: begin
									if (in_q.locked) begin
										for (int i = 0; i < sts_pkg::LANES; i++) begin
											step_ctr_q[i] <= '0;
										end
										xport_q  <= XP_PLAY;
										adv_ok_q <= 1'b0;
										state_q  <= ST_DIV;
									end
								end
								XP_PLAY: begin
									adv_ok_q <= 1'b1;
									state_q  <= ST_DIV;
								end
								default: begin
									xport_q <= XP_STOP;
								end
							endcase
						end
						sts_pkg::KIND_TOGGLE: begin
							xport_q <= (xport_q == XP_STOP) ? XP_RESET : XP_STOP;
						end
						sts_pkg::KIND_SEL_BLK: begin
							if (blk_ok) begin
								sel_blk_q <= sts_pkg::BLK_W'(in_q.block);
							end
						end
						default: begin
						end
					endcase
				end
				ST_DIV: begin
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					sub_step_q <= sts_pkg::SUB_W'(rem);
					if (adv_ok_q && in_q.sub == 8'd0) begin
						play_blk_q <= sel_blk_q;
					end
					rd_idx_q  <= '0;
					rd_run_q  <= 1'b1;
					wb_vld_s1 <= 1'b0;
					acc_q     <= '0;
					state_q   <= (adv_ok_q && rem == 8'd0) ? ST_ADV : ST_MASK;
				end
				ST_ADV: begin
					// Read loop length of one lane a cycle, update it the cycle after.
					wb_vld_s1 <= rd_run_q;
					wb_idx_s1 <= rd_idx_q;
					if (rd_run_q) begin
						rd_idx_q <= rd_idx_q + 1'b1;
						if (int'(rd_idx_q) == sts_pkg::LANES - 1) begin
							rd_run_q <= 1'b0;
						end
					end
					if (wb_vld_s1) begin
						step_ctr_q[wb_idx_s1] <= ctr_wrap ? '0 : sts_pkg::STEP_W'(ctr_nxt);
						if (int'(wb_idx_s1) == sts_pkg::LANES - 1) begin
							rd_idx_q  <= '0;
							rd_run_q  <= 1'b1;
							wb_vld_s1 <= 1'b0;
							state_q   <= ST_MASK;
						end
					end
				end
				ST_MASK: begin
					// Read one trigger lane's pattern word a cycle, test its bit after.
					wb_vld_s1 <= rd_run_q;
					wb_idx_s1 <= rd_idx_q;
					acc_q     <= mask_nxt;
					if (rd_run_q) begin
						rd_idx_q <= rd_idx_q + 1'b1;
						if (int'(rd_idx_q) == sts_pkg::MASK_N - 1) begin
							rd_run_q <= 1'b0;
						end
					end
					if (wb_vld_s1 && int'(wb_idx_s1) == sts_pkg::MASK_N - 1) begin
						wb_vld_s1     <= 1'b0;
						res_mask_q    <= mask_nxt;
						res_changed_q <= (mask_nxt != last_mask_q);
						last_mask_q   <= mask_nxt;
						state_q       <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!rsp_vld_q || rsp.ready) begin
						rsp_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// One request at a time: acceptance always drops ready for the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request accepted while previous request still in progress");

	// A changed mask is only reported from a tick that left the transport in PLAY.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.trigger_changed |-> rsp.data.playing)
		else $error("trigger change reported outside PLAY");

	// Unlock requests only come from ticks in STOP.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.clock_unlock |-> !rsp.data.playing)
		else $error("clock unlock reported while playing");

	// No result can appear before the memory sweep after reset has finished.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !rsp.valid && !req.ready)
		else $error("channel active during memory sweep");

	// A result pending at the output is never overwritten before it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("pending result lost or changed");

endmodule

FILE: test/sts_checker.sv
// Request and result monitor for the step trigger sequencer, with its own transport model.
`timescale 1ns / 100ps

module sts_checker (
	input  logic clk,
	input  logic arst_n,
	sts_req_if   req,
	sts_rsp_if   rsp,
	output int   mismatch_count,
	output int   outstanding
);

	typedef enum logic [1:0] {XPORT_STOP, XPORT_RESET, XPORT_PLAY} transport_t;

	// Shadow copy of the sequencer state.
	logic [sts_pkg::PAT_W-1:0]
		pat_mem [sts_pkg::LANES][sts_pkg::BLOCKS][sts_pkg::STEPS];
	logic [sts_pkg::LEN_W-1:0]  loop_len [sts_pkg::LANES][sts_pkg::BLOCKS];
	logic [sts_pkg::STEP_W-1:0] step_cnt [sts_pkg::LANES];
	logic [sts_pkg::SUB_W-1:0]  sub_pos;
	transport_t                 xport;
	logic [sts_pkg::BLK_W-1:0]  sel_blk;
	logic [sts_pkg::BLK_W-1:0]  play_blk;
	logic [sts_pkg::MASK_W-1:0] last_mask;

	// Results still owed by the block, oldest first.
	sts_pkg::rsp_t awaited_results [$];
	sts_pkg::rsp_t got;
	sts_pkg::rsp_t want;

	task automatic report(input string what, input int got_val, input int want_val);
		$display("%0t: %s: got %0d, want %0d", $time, what, got_val, want_val);
		mismatch_count++;
	endtask

	// Applies one request to the shadow state and returns the result it must produce.
	function automatic sts_pkg::rsp_t trigger_for_request(input sts_pkg::req_t r);
		sts_pkg::rsp_t             res;
		logic [sts_pkg::LEN_W-1:0] nxt;
		res.trigger_mask    = last_mask;
		res.trigger_changed = 1'b0;
		res.clock_unlock    = 1'b0;
		case (r.kind)
			sts_pkg::KIND_TICK: begin
				if (xport == XPORT_STOP) begin
					res.clock_unlock = 1'b1;
				end else if (xport == XPORT_RESET) begin
					// A locked clock restarts the pattern from step zero.
					if (r.locked) begin
						foreach (step_cnt[i]) step_cnt[i] = '0;
						sub_pos = sts_pkg::SUB_W'(r.sub % sts_pkg::SUBSTEPS);
						xport   = XPORT_PLAY;
					end
				end else begin
					sub_pos = sts_pkg::SUB_W'(r.sub % sts_pkg::SUBSTEPS);
					if (r.sub == 0) play_blk = sel_blk;
					// Every lane moves one step at the start of a step and wraps at its length.
					if (sub_pos == 0) begin
						for (int i = 0; i < sts_pkg::LANES; i++) begin
							nxt = sts_pkg::LEN_W'(step_cnt[i]) + 1'b1;
							if (nxt >= loop_len[i][play_blk] || nxt >= sts_pkg::STEPS) nxt = '0;
							step_cnt[i] = sts_pkg::STEP_W'(nxt);
						end
					end
				end
				if (xport == XPORT_PLAY) begin
					res.trigger_mask = '0;
					for (int i = 0; i < sts_pkg::MASK_N; i++)
						res.trigger_mask[i] = pat_mem[i][play_blk][step_cnt[i]][sub_pos];
					res.trigger_changed = (res.trigger_mask != last_mask);
					last_mask = res.trigger_mask;
				end
			end
			sts_pkg::KIND_TOGGLE: begin
				xport = (xport == XPORT_STOP) ? XPORT_RESET : XPORT_STOP;
			end
			sts_pkg::KIND_WR_PAT: begin
				pat_mem[r.lane][r.block][r.step] = r.pattern_word;
			end
			sts_pkg::KIND_WR_LEN: begin
				loop_len[r.lane][r.block] = r.loop_length;
			end
			sts_pkg::KIND_SEL_BLK: begin
				sel_blk = r.block;
			end
			default: begin
			end
		endcase
		res.playing = (xport == XPORT_PLAY);
		return res;
	endfunction

	// Results are matched before new requests are queued, since no request answers on its own edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (pat_mem[l, b, s]) pat_mem[l][b][s] = '0;
			foreach (loop_len[l, b]) loop_len[l][b] = sts_pkg::LEN_W'(sts_pkg::STEPS);
			foreach (step_cnt[i]) step_cnt[i] = '0;
			sub_pos   = '0;
			xport     = XPORT_STOP;
			sel_blk   = '0;
			play_blk  = '0;
			last_mask = '0;
			awaited_results.delete();
			mismatch_count = 0;
			outstanding    = 0;
		end else begin
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				got = rsp.data;
				if (awaited_results.size() == 0) begin
					report("result with no request waiting, trigger_mask",
						int'(got.trigger_mask), 0);
				end else begin
					want = awaited_results.pop_front();
					if (got.trigger_mask !== want.trigger_mask)
						report("trigger_mask", int'(got.trigger_mask), int'(want.trigger_mask));
					if (got.trigger_changed !== want.trigger_changed)
						report("trigger_changed", int'(got.trigger_changed),
							int'(want.trigger_changed));
					if (got.playing !== want.playing)
						report("playing", int'(got.playing), int'(want.playing));
					if (got.clock_unlock !== want.clock_unlock)
						report("clock_unlock", int'(got.clock_unlock), int'(want.clock_unlock));
				end
			end
			if (req.valid === 1'b1 && req.ready === 1'b1)
				awaited_results.push_back(trigger_for_request(req.data));
			outstanding = awaited_results.size();
		end
	end

endmodule

FILE: test/tb_top.sv
// Top of the step trigger sequencer testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

	localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
	localparam int RANDOM_REQUESTS = 870;
	localparam int HOLD_AT         = 300;
	localparam int PAUSE_AT        = 600;
	localparam int LONG_HOLD       = 400;
	localparam int IDLE_LIMIT      = 20000;
	localparam int DRAIN_CYCLES    = 64;
	localparam int LEN_MAX         = (1 << sts_pkg::LEN_W) - 1;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   outstanding;
	int   idle_cycles = 0;
	int   burst_left  = 0;
	int   sub_count   = 0;
	int   sub_wrap    = 24;
	bit   long_hold   = 1'b0;

	sts_req_if req_if();
	sts_rsp_if rsp_if();

	step_trigger_sequencer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	sts_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_if),
		.rsp            (rsp_if),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Ends the run when neither channel moves for too long.
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Result side: phases of steady, patterned and random stalls, plus one long hold on request.
	initial begin : receiver
		int         phase_left;
		int         mode;
		logic [7:0] stall_pat;
		phase_left = 0;
		mode       = 0;
		stall_pat  = 8'hFF;
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				rsp_if.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				long_hold = 1'b0;
			end else begin
				if (phase_left == 0) begin
					mode       = $urandom_range(0, 2);
					phase_left = $urandom_range(16, 96);
					stall_pat  = 8'($urandom);
					if (stall_pat == 0) stall_pat = 8'h01;
				end
				phase_left--;
				case (mode)
					0: begin
						rsp_if.ready <= 1'b1;
					end
					1: begin
						rsp_if.ready <= stall_pat[0];
						stall_pat = {stall_pat[0], stall_pat[7:1]};
					end
					default: begin
						rsp_if.ready <= ($urandom_range(0, 3) != 0);
					end
				endcase
			end
		end
	end

	function automatic sts_pkg::req_t shape(input logic [2:0] kind, input int sub,
		input int locked, input int lane, input int blk, input int stp, input int word,
		input int len);
		sts_pkg::req_t r;
		r.kind         = kind;
		r.sub          = 8'(sub);
		r.locked       = 1'(locked);
		r.lane         = 4'(lane);
		r.block        = 4'(blk);
		r.step         = 4'(stp);
		r.pattern_word = 12'(word);
		r.loop_length  = 5'(len);
		return r;
	endfunction

	// Mostly a small address range, so that writes land where the pattern plays.
	function automatic logic [3:0] focus(input int narrow_hi);
		return ($urandom_range(0, 4) != 0) ? 4'($urandom_range(0, narrow_hi)) : 4'($urandom);
	endfunction

	// Offers one request at a falling edge and returns at a falling edge after it is taken.
	task automatic send_request(input sts_pkg::req_t r);
		req_if.data  <= r;
		req_if.valid <= 1'b1;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 10);
		end
	endtask

	// Random traffic: mostly a running master clock with edits mixed in.
	task automatic next_random(output sts_pkg::req_t r, output bit counted);
		int roll;
		roll = $urandom_range(0, 99);
		r = shape(sts_pkg::KIND_TICK, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom);
		counted = 1'b1;
		if (roll < 58) begin
			r.sub    = 8'(sub_count);
			r.locked = ($urandom_range(0, 9) != 0);
			if (sub_count + 1 >= sub_wrap) begin
				sub_count = 0;
				case ($urandom_range(0, 3))
					0: sub_wrap = sts_pkg::SUBSTEPS;
					1: sub_wrap = 2 * sts_pkg::SUBSTEPS;
					2: sub_wrap = 8 * sts_pkg::SUBSTEPS;
					default: sub_wrap = 256;
				endcase
			end else begin
				sub_count++;
			end
		end else if (roll < 72) begin
			r.kind  = sts_pkg::KIND_WR_PAT;
			r.lane  = focus(7);
			r.block = focus(3);
			r.step  = focus(7);
		end else if (roll < 80) begin
			r.kind  = sts_pkg::KIND_WR_LEN;
			r.lane  = focus(7);
			r.block = focus(3);
			case ($urandom_range(0, 9))
				0: r.loop_length = '0;
				1: r.loop_length = 5'(sts_pkg::STEPS);
				2: r.loop_length = 5'($urandom_range(sts_pkg::STEPS + 1, LEN_MAX));
				default: r.loop_length = 5'($urandom_range(1, 8));
			endcase
		end else if (roll < 85) begin
			r.kind  = sts_pkg::KIND_SEL_BLK;
			r.block = focus(3);
		end else if (roll < 89) begin
			r.kind = sts_pkg::KIND_TOGGLE;
		end else if (roll < 95) begin
			r.kind  = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
			counted = 1'b0;
		end
	endtask

	initial begin : stimulus
		sts_pkg::req_t r;
		bit            counted;
		int            n;
		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: tick while stopped, edge addresses and lengths, spare kinds, transport walk.
		send_request(shape(sts_pkg::KIND_TICK, 0, 1, 0, 0, 0, 0, 0));
		send_request(shape(sts_pkg::KIND_WR_PAT, 0, 0, 0, 0, 0, 12'hFFF, 0));
		send_request(shape(sts_pkg::KIND_WR_PAT, 0, 0, sts_pkg::LANES - 1,
			sts_pkg::BLOCKS - 1, sts_pkg::STEPS - 1, 12'hAAA, 0));
		send_request(shape(sts_pkg::KIND_WR_PAT, 0, 0, 7, 0, 0, 12'h555, 0));
		send_request(shape(sts_pkg::KIND_WR_PAT, 0, 0, 1, 0, 1, 12'h001, 0));
		send_request(shape(sts_pkg::KIND_WR_LEN, 0, 0, 0, 0, 0, 0, 0));
		send_request(shape(sts_pkg::KIND_WR_LEN, 0, 0, 1, 0, 0, 0, 2));
		send_request(shape(sts_pkg::KIND_WR_LEN, 0, 0, 2, 0, 0, 0, 1));
		send_request(shape(sts_pkg::KIND_WR_LEN, 0, 0, sts_pkg::LANES - 1,
			sts_pkg::BLOCKS - 1, 0, 0, LEN_MAX));
		send_request(shape(sts_pkg::KIND_SEL_BLK, 0, 0, 0, sts_pkg::BLOCKS - 1, 0, 0, 0));
		send_request(shape(sts_pkg::KIND_SEL_BLK, 0, 0, 0, 0, 0, 0, 0));
		send_request(shape(KIND_SPARE_FIRST, 0, 1, 3, 3, 3, 12'hFFF, 16));
		send_request(shape(KIND_SPARE_LAST, 0, 1, 3, 3, 3, 12'hFFF, 16));
		send_request(shape(sts_pkg::KIND_TOGGLE, 0, 0, 0, 0, 0, 0, 0));
		send_request(shape(sts_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
		send_request(shape(sts_pkg::KIND_TICK, 0, 1, 0, 0, 0, 0, 0));
		send_request(shape(sts_pkg::KIND_TICK, 1, 1, 0, 0, 0, 0, 0));
		send_request(shape(sts_pkg::KIND_TICK, 11, 1, 0, 0, 0, 0, 0));
		send_request(shape(sts_pkg::KIND_TICK, 12, 1, 0, 0, 0, 0, 0));
		send_request(shape(sts_pkg::KIND_TICK, 255, 1, 0, 0, 0, 0, 0));
		send_request(shape(sts_pkg::KIND_TICK, 24, 1, 0, 0, 0, 0, 0));
		send_request(shape(sts_pkg::KIND_TOGGLE, 0, 0, 0, 0, 0, 0, 0));
		send_request(shape(sts_pkg::KIND_TOGGLE, 0, 0, 0, 0, 0, 0, 0));
		send_request(shape(sts_pkg::KIND_TOGGLE, 0, 0, 0, 0, 0, 0, 0));
		send_request(shape(sts_pkg::KIND_TICK, 5, 0, 0, 0, 0, 0, 0));

		// Random part, with one long result hold and one full drain along the way.
		n = 0;
		while (n < RANDOM_REQUESTS) begin
			next_random(r, counted);
			if (counted && n == HOLD_AT) long_hold = 1'b1;
			if (counted && n == PAUSE_AT) begin
				req_if.valid <= 1'b0;
				do @(negedge clk); while (outstanding != 0);
			end
			send_request(r);
			if (counted) n++;
		end

		// Drain and give the verdict.
		req_if.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
